// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VNU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VNU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VNU_ASSERT(lbl, clk, rst_n, prop, msg)
`define VNU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/vnu_pkg.sv =====
// ---------------------------------------------------------------------------
// vnu_pkg
// shared constants of the vector normalize unit
// ---------------------------------------------------------------------------
package vnu_pkg;
  localparam int CompWidthDef = 32;
  localparam int UnitW        = 32;
  localparam int MagW         = 33;
  localparam int DivSteps     = 31;
  localparam int OutDataW     = ((4 * UnitW + MagW + 7) / 8) * 8;
endpackage

// ===== rtl/vector_normalize_unit.sv =====
// ---------------------------------------------------------------------------
// vector_normalize_unit
// four-component fixed-point vector normalization pipeline
// ---------------------------------------------------------------------------
// Takes one word per clock while not stalled and returns one word per input,
// in order, through one stage for the absolute values, one for the squares,
// one for the sum, one per root bit of the square root (COMP_WIDTH + 1), one
// per quotient bit of the four dividers (31) and the output register. The
// whole pipeline moves together; it holds while the output word is not taken
// and its last stage is full.
`include "assert_macros.svh"

module vector_normalize_unit
  import vnu_pkg::*;
#(
  parameter int COMP_WIDTH = CompWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // comp_x, comp_y, comp_z, comp_w
  input  logic [((4*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // unit_x, unit_y, unit_z, unit_w, magnitude
  output logic [OutDataW-1:0]           m_axis_tdata,
  // zero_length
  output logic [0:0]                    m_axis_tuser
);
  localparam int W     = COMP_WIDTH;
  localparam int SqW   = 2 * W;
  localparam int SumW  = 2 * W + 2;
  localparam int RootW = W + 1;
  localparam int RemW  = W + 2;
  localparam int QW    = DivSteps;
  localparam int SqrtS = W + 1;
  localparam int NStg  = 3 + SqrtS + DivSteps + 1;

  logic            en;
  logic [NStg-1:0] vld_q;

  assign en            = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // absolute values
  logic [W-1:0]   abs_q [4];
  logic [3:0]     neg_a_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg_a_q[i] <= s_axis_tdata[i*W + W-1];
        abs_q[i]   <= s_axis_tdata[i*W + W-1] ? W'(-s_axis_tdata[i*W +: W])
                                              : s_axis_tdata[i*W +: W];
      end
    end
  end

  // squares
  logic [SqW-1:0] sq_q [4];
  logic [W-1:0]   abs_b_q [4];
  logic [3:0]     neg_b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i]    <= SqW'(abs_q[i]) * SqW'(abs_q[i]);
        abs_b_q[i] <= abs_q[i];
      end
      neg_b_q <= neg_a_q;
    end
  end

  // sum of squares, feeds the root pipeline
  logic [SumW-1:0]  rad_q  [SqrtS+1];
  logic [RootW-1:0] root_q [SqrtS+1];
  logic [RemW-1:0]  rem_q  [SqrtS+1];
  logic [W-1:0]     sabs_q [SqrtS+1][4];
  logic [3:0]       sneg_q [SqrtS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q[0]  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]) + SumW'(sq_q[3]);
      root_q[0] <= '0;
      rem_q[0]  <= '0;
      sabs_q[0] <= abs_b_q;
      sneg_q[0] <= neg_b_q;
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < SqrtS; j++) begin : g_sqrt
    logic [RemW+1:0] rem_n;
    logic [RemW+1:0] trial;
    logic [RemW+1:0] diff;
    logic            ge;
    always_comb begin
      rem_n = {rem_q[j], rad_q[j][SumW-1 -: 2]};
      trial = (RemW+2)'({root_q[j], 2'b01});
      diff  = rem_n - trial;
      ge    = rem_n >= trial;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[j+1]  <= {rad_q[j][SumW-3:0], 2'b00};
        root_q[j+1] <= {root_q[j][RootW-2:0], ge};
        rem_q[j+1]  <= ge ? diff[RemW-1:0] : rem_n[RemW-1:0];
        sabs_q[j+1] <= sabs_q[j];
        sneg_q[j+1] <= sneg_q[j];
      end
    end
  end

  // four dividers, one quotient bit per stage
  logic [RootW-1:0] den_q [DivSteps];
  logic [RootW-1:0] dr_q  [DivSteps][4];
  logic [QW-1:0]    dq_q  [DivSteps][4];
  logic [3:0]       dneg_q [DivSteps];

  for (genvar l = 0; l < 4; l++) begin : g_div0
    logic [RootW-1:0] num;
    logic             ge;
    assign num = RootW'(sabs_q[SqrtS][l]);
    assign ge  = num >= root_q[SqrtS];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[0][l] <= ge ? num - root_q[SqrtS] : num;
        dq_q[0][l] <= QW'(ge);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0]  <= root_q[SqrtS];
      dneg_q[0] <= sneg_q[SqrtS];
    end
  end

  for (genvar k = 1; k < DivSteps; k++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [RootW:0] r2;
      logic [RootW:0] d2;
      logic [RootW:0] diff;
      logic           ge;
      always_comb begin
        r2   = {dr_q[k-1][l], 1'b0};
        d2   = {1'b0, den_q[k-1]};
        diff = r2 - d2;
        ge   = r2 >= d2;
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dr_q[k][l] <= ge ? diff[RootW-1:0] : r2[RootW-1:0];
          dq_q[k][l] <= {dq_q[k-1][l][QW-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[k]  <= den_q[k-1];
        dneg_q[k] <= dneg_q[k-1];
      end
    end
  end

  // output register
  logic [MagW-1:0]  mag;
  logic             zero_len;
  logic [RootW-1:0] len;
  assign len      = den_q[DivSteps-1];
  assign zero_len = len == '0;

  if (RootW <= MagW) begin : g_mag_fit
    assign mag = MagW'(len);
  end else begin : g_mag_sat
    assign mag = (|len[RootW-1:MagW]) ? '1 : len[MagW-1:0];
  end

  logic [UnitW-1:0] unit_q [4];
  logic [MagW-1:0]  mag_q;
  logic             zero_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (zero_len) begin
          unit_q[i] <= '0;
        end else if (dneg_q[DivSteps-1][i]) begin
          unit_q[i] <= -UnitW'(dq_q[DivSteps-1][i]);
        end else begin
          unit_q[i] <= UnitW'(dq_q[DivSteps-1][i]);
        end
      end
      mag_q  <= mag;
      zero_q <= zero_len;
    end
  end

  assign m_axis_tdata = OutDataW'({mag_q, unit_q[3], unit_q[2], unit_q[1], unit_q[0]});
  assign m_axis_tuser = zero_q;

  `VNU_ASSERT(a_zero_mag, clk_i, rst_ni, m_axis_tvalid |-> (zero_q == (mag_q == '0)), "zero flag and magnitude disagree")
  `VNU_ASSERT(a_zero_units, clk_i, rst_ni, (m_axis_tvalid && zero_q) |-> (unit_q[0] == '0 && unit_q[1] == '0 && unit_q[2] == '0 && unit_q[3] == '0), "zero vector gives nonzero units")
  `VNU_ASSERT(a_unit_range, clk_i, rst_ni, m_axis_tvalid |-> ($signed(unit_q[0]) <= $signed(32'sh4000_0000) && $signed(unit_q[0]) >= $signed(-32'sh4000_0000)), "unit component out of range")
  `VNU_ASSERT_NEXT(a_hold, clk_i, rst_ni, !en, $stable(vld_q), "pipeline moved while stalled")
endmodule

// ===== test/tb_vector_normalize_unit.sv =====
// ---------------------------------------------------------------------------
// tb_vector_normalize_unit
// self-checking bench for the four-component vector normalize unit
// ---------------------------------------------------------------------------
// Sends vectors over the input stream and predicts length, unit components and
// the zero flag for each accepted word. Results are compared in order against
// a queue of predictions. The bench runs through phases with no idling, sender
// gaps, receiver stalls and both, and twice drains the pipeline fully.
// ---------------------------------------------------------------------------

class norm_scoreboard;
  localparam int OutDataW_C = vnu_pkg::OutDataW;

  typedef struct packed {
    logic        zero;
    logic [32:0] mag;
    logic [31:0] uw, uz, uy, ux;
  } norm_t;

  norm_t pending_q[$];
  int    errors;

  function new();
    errors = 0;
  endfunction

  function automatic logic [31:0] unit_of(logic [31:0] c, logic [32:0] len);
    logic [31:0] a;
    logic [63:0] q;
    a = c[31] ? -c : c;
    q = ({32'd0, a} << 30) / {31'd0, len};
    return c[31] ? -q[31:0] : q[31:0];
  endfunction

  function void note_vector(logic [127:0] v);
    logic [31:0]  c[4];
    logic [31:0]  a;
    logic [65:0]  sum;
    logic [32:0]  root, trial;
    logic [65:0]  sq;
    norm_t        e;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      c[i] = v[32*i +: 32];
      a = c[i][31] ? -c[i] : c[i];
      sum += {34'd0, a} * {34'd0, a};
    end
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (33'd1 << b);
      sq = {33'd0, trial} * {33'd0, trial};
      if (sq <= sum) root = trial;
    end
    e = '0;
    if (root == 0) begin
      e.zero = 1'b1;
    end else begin
      e.mag = root;
      e.ux = unit_of(c[0], root);
      e.uy = unit_of(c[1], root);
      e.uz = unit_of(c[2], root);
      e.uw = unit_of(c[3], root);
    end
    pending_q.push_back(e);
  endfunction

  function void check_result(logic [OutDataW_C-1:0] d, logic z);
    norm_t e;
    if (pending_q.size() == 0) begin
      $display("%0t unexpected word %h", $time, d);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (d[31:0] !== e.ux) begin
      $display("%0t unit_x exp %h got %h", $time, e.ux, d[31:0]); errors++;
    end
    if (d[63:32] !== e.uy) begin
      $display("%0t unit_y exp %h got %h", $time, e.uy, d[63:32]); errors++;
    end
    if (d[95:64] !== e.uz) begin
      $display("%0t unit_z exp %h got %h", $time, e.uz, d[95:64]); errors++;
    end
    if (d[127:96] !== e.uw) begin
      $display("%0t unit_w exp %h got %h", $time, e.uw, d[127:96]); errors++;
    end
    if (d[160:128] !== e.mag) begin
      $display("%0t magnitude exp %h got %h", $time, e.mag, d[160:128]); errors++;
    end
    if (z !== e.zero) begin
      $display("%0t zero_length exp %b got %b", $time, e.zero, z); errors++;
    end
  endfunction
endclass

module tb_vector_normalize_unit;
  import vnu_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;

  norm_scoreboard sb;
  int             send_idle_pct, recv_stall_pct;
  longint         cycles = 0;

  vector_normalize_unit dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL vector_normalize_unit");
      $finish;
    end
  end

  // receiver with random stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131071)) - 65536);
      2: return {{16{1'b0}}, 16'($urandom)};
      3: return 32'h0;
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_vector({w, z, y, x});
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_vector(rand_comp(), rand_comp(), 32'h0, 32'h0);
        1: send_vector(rand_comp(), rand_comp(), rand_comp(), 32'h0);
        default: send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      endcase
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero, extremes, single axis, 2d and 3d
    send_vector(32'h0, 32'h0, 32'h0, 32'h0);
    send_vector(32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_vector(32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h0, 32'h0, 32'h0, 32'h1);
    send_vector(32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    send_vector(32'h1, 32'h1, 32'h1, 32'h1);
    send_vector(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_vector(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
    send_vector(32'hfffd_0000, 32'h0004_0000, 32'h0, 32'h0);
    send_vector(32'h0, 32'hffff_0000, 32'h0, 32'h0);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    send_vector(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 32'h0000_0001);
    send_vector(32'h0, 32'h0, 32'h0, 32'h0);

    send_random(220);
    drain();
    send_idle_pct = 61;
    send_random(220);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    send_random(220);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    send_random(220);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(40);

    drain();
    repeat (120) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS vector_normalize_unit");
    end else begin
      $display("FAIL vector_normalize_unit");
    end
    $finish;
  end
endmodule
